// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== rtl/core/saq_pkg.sv =====
// ----------------------------------------------------------------------------
// saq_pkg
// Shared constants, types and helpers of the stream admission queue.
// ----------------------------------------------------------------------------
package saq_pkg;

    // Ring size and tag compare width
    localparam int DEPTH    = 16;
    localparam int TAG_BITS = 32;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int TAG_W    = (TAG_BITS < 32) ? TAG_BITS : 32;
    localparam int ID_W     = 32;

    // Stream bus widths
    localparam int ACT_W       = 3;
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 104;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_PUSH       = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PLAY_CHECK = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INV_AT     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_INV_AFTER  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_NEW_TRACK  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_NEW_STREAM = 3'd5;
    // Reserved codes, no effect and an all-zero result
    localparam logic [ACT_W-1:0] ACT_RSVD6      = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RSVD7      = 3'd7;

    // Play check answers
    localparam logic [1:0] PLAY_NO    = 2'd0;
    localparam logic [1:0] PLAY_YES   = 2'd1;
    localparam logic [1:0] PLAY_LATER = 2'd2;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [TAG_W-1:0] tag_t;
    typedef logic [ID_W-1:0]  id_t;

    typedef struct packed {
        tag_t style_tag;
        tag_t provider_tag;
    } tag_pair_t;

    typedef struct packed {
        tag_t style_tag;
        tag_t provider_tag;
        id_t  track_number;
        id_t  stream_number;
        logic play_now;
    } entry_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        tag_t             style_tag;
        tag_t             provider_tag;
        id_t              track_number;
        id_t              stream_number;
        logic             play_now;
    } item_t;

    typedef struct packed {
        logic [1:0] play_code;
        logic       stop_request;
        id_t        stop_track;
        id_t        stop_stream;
        id_t        issued_id;
        logic       full_error;
    } result_t;

    typedef struct packed {
        logic   we;
        ptr_t   addr;
        entry_t data;
    } mem_wr_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_status_t;

    // Ring increment with wrap at DEPTH
    function automatic ptr_t ptr_next(input ptr_t p);
        if (p == PTR_W'(DEPTH - 1))
        begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

endpackage

// ===== rtl/core/saq_ring_mem.sv =====
// ----------------------------------------------------------------------------
// saq_ring_mem
// Entry store of the ring: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module saq_ring_mem (
    input  logic             clk,
    input  saq_pkg::mem_wr_t wr,
    input  saq_pkg::ptr_t    rd_addr,
    output saq_pkg::entry_t  rd_data
);

    saq_pkg::entry_t mem_array [0:saq_pkg::DEPTH-1];
    saq_pkg::entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem_array[wr.addr] <= wr.data;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_array[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/saq_match.sv =====
// ----------------------------------------------------------------------------
// saq_match
// Shared tag compare unit: style and provider tags must both be equal.
// ----------------------------------------------------------------------------
module saq_match (
    input  saq_pkg::tag_pair_t a,
    input  saq_pkg::tag_pair_t b,
    output logic               hit
);

    assign hit = (a.style_tag == b.style_tag) && (a.provider_tag == b.provider_tag);

endmodule

// ===== rtl/core/saq_seq.sv =====
// ----------------------------------------------------------------------------
// saq_seq
// Sequencer: pointers, playing record, id counters and the ring walks.
// ----------------------------------------------------------------------------
module saq_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  saq_pkg::item_t        in_item,
    output saq_pkg::seq_status_t  status,
    output saq_pkg::result_t      result,
    input  logic                  result_take,
    output saq_pkg::mem_wr_t      mem_wr,
    output saq_pkg::ptr_t         mem_rd_addr,
    input  saq_pkg::entry_t       mem_rd_data,
    output saq_pkg::tag_pair_t    cmp_a,
    output saq_pkg::tag_pair_t    cmp_b,
    input  logic                  cmp_hit
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_EXEC    = 3'd1;
    localparam logic [2:0] ST_FIND    = 3'd2;
    localparam logic [2:0] ST_SKIP    = 3'd3;
    localparam logic [2:0] ST_COMPACT = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;

    logic [2:0]       state_reg, state_next;
    saq_pkg::item_t   item_reg, item_next;
    saq_pkg::result_t res_reg, res_next;
    saq_pkg::ptr_t    head_reg, head_next;
    saq_pkg::ptr_t    tail_reg, tail_next;
    saq_pkg::ptr_t    idx_reg, idx_next;
    saq_pkg::ptr_t    prev_reg, prev_next;
    logic             at_head_reg, at_head_next;
    logic             playing_valid_reg, playing_valid_next;
    saq_pkg::entry_t  playing_reg, playing_next;
    saq_pkg::id_t     track_cnt_reg, track_cnt_next;
    saq_pkg::id_t     stream_cnt_reg, stream_cnt_next;

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            head_reg          <= '0;
            tail_reg          <= '0;
            idx_reg           <= '0;
            prev_reg          <= '0;
            at_head_reg       <= 1'b0;
            playing_valid_reg <= 1'b0;
            playing_reg       <= '0;
            track_cnt_reg     <= '0;
            stream_cnt_reg    <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            head_reg          <= head_next;
            tail_reg          <= tail_next;
            idx_reg           <= idx_next;
            prev_reg          <= prev_next;
            at_head_reg       <= at_head_next;
            playing_valid_reg <= playing_valid_next;
            playing_reg       <= playing_next;
            track_cnt_reg     <= track_cnt_next;
            stream_cnt_reg    <= stream_cnt_next;
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    // Next-state logic; memory read of idx_next lands next cycle as entry[idx_reg]
    always_comb
    begin
        state_next         = state_reg;
        item_next          = item_reg;
        res_next           = res_reg;
        head_next          = head_reg;
        tail_next          = tail_reg;
        idx_next           = idx_reg;
        prev_next          = prev_reg;
        at_head_next       = at_head_reg;
        playing_valid_next = playing_valid_reg;
        playing_next       = playing_reg;
        track_cnt_next     = track_cnt_reg;
        stream_cnt_next    = stream_cnt_reg;

        mem_wr.we                 = 1'b0;
        mem_wr.addr               = tail_reg;
        mem_wr.data.style_tag     = item_reg.style_tag;
        mem_wr.data.provider_tag  = item_reg.provider_tag;
        mem_wr.data.track_number  = item_reg.track_number;
        mem_wr.data.stream_number = item_reg.stream_number;
        mem_wr.data.play_now      = item_reg.play_now;

        cmp_a.style_tag    = mem_rd_data.style_tag;
        cmp_a.provider_tag = mem_rd_data.provider_tag;
        cmp_b.style_tag    = item_reg.style_tag;
        cmp_b.provider_tag = item_reg.provider_tag;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_item;
                    res_next   = '0;
                    idx_next   = head_reg;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                // compare unit looks at the playing record here
                cmp_a.style_tag    = playing_reg.style_tag;
                cmp_a.provider_tag = playing_reg.provider_tag;
                state_next         = ST_DONE;
                case (item_reg.action)
                    saq_pkg::ACT_PUSH:
                    begin
                        if (saq_pkg::ptr_next(tail_reg) == head_reg)
                        begin
                            res_next.full_error = 1'b1;
                        end
                        else
                        begin
                            mem_wr.we = 1'b1;
                            tail_next = saq_pkg::ptr_next(tail_reg);
                        end
                    end

                    saq_pkg::ACT_PLAY_CHECK:
                    begin
                        if ((head_reg != tail_reg) &&
                            (mem_rd_data.track_number == item_reg.track_number) &&
                            (mem_rd_data.stream_number == item_reg.stream_number))
                        begin
                            playing_valid_next = 1'b1;
                            playing_next       = mem_rd_data;
                            head_next          = saq_pkg::ptr_next(head_reg);
                            res_next.play_code = mem_rd_data.play_now ?
                                                 saq_pkg::PLAY_YES : saq_pkg::PLAY_LATER;
                        end
                    end

                    saq_pkg::ACT_INV_AT,
                    saq_pkg::ACT_INV_AFTER:
                    begin
                        if (playing_valid_reg && cmp_hit)
                        begin
                            // skip the run at the head
                            at_head_next = 1'b1;
                            state_next   = ST_SKIP;
                            if (item_reg.action == saq_pkg::ACT_INV_AT)
                            begin
                                res_next.stop_request = 1'b1;
                                res_next.stop_track   = playing_reg.track_number;
                                res_next.stop_stream  = playing_reg.stream_number;
                            end
                        end
                        else
                        begin
                            at_head_next = 1'b0;
                            state_next   = ST_FIND;
                        end
                    end

                    saq_pkg::ACT_NEW_TRACK:
                    begin
                        res_next.issued_id = track_cnt_reg;
                        track_cnt_next     = track_cnt_reg + saq_pkg::ID_W'(1);
                    end

                    saq_pkg::ACT_NEW_STREAM:
                    begin
                        res_next.issued_id = stream_cnt_reg;
                        stream_cnt_next    = stream_cnt_reg + saq_pkg::ID_W'(1);
                    end

                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            // Walk to the first matching entry
            ST_FIND:
            begin
                if (idx_reg == tail_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (cmp_hit)
                begin
                    prev_next    = idx_reg;
                    at_head_next = (idx_reg == head_reg);
                    idx_next     = saq_pkg::ptr_next(idx_reg);
                    state_next   = ST_SKIP;
                end
                else
                begin
                    idx_next = saq_pkg::ptr_next(idx_reg);
                end
            end

            // Walk past the run of matching entries
            ST_SKIP:
            begin
                if ((idx_reg != tail_reg) && cmp_hit)
                begin
                    idx_next = saq_pkg::ptr_next(idx_reg);
                end
                else if (item_reg.action == saq_pkg::ACT_INV_AFTER)
                begin
                    tail_next  = idx_reg;
                    state_next = ST_DONE;
                end
                else if (at_head_reg)
                begin
                    head_next  = idx_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_COMPACT;
                end
            end

            // Shift the remaining entries down over the removed run
            ST_COMPACT:
            begin
                if (idx_reg == tail_reg)
                begin
                    tail_next  = prev_reg;
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_wr.we   = 1'b1;
                    mem_wr.addr = prev_reg;
                    mem_wr.data = mem_rd_data;
                    prev_next   = saq_pkg::ptr_next(prev_reg);
                    idx_next    = saq_pkg::ptr_next(idx_reg);
                end
            end

            ST_DONE:
            begin
                if (result_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign mem_rd_addr = idx_next;
    assign status.idle = (state_reg == ST_IDLE);
    assign status.done = (state_reg == ST_DONE);
    assign result      = res_reg;

endmodule

// ===== rtl/core/stream_admission_queue_unit.sv =====
// Path: push, play check, id requests and reserved codes pass from idle through exec
// to done; invalidations walk the ring one entry per cycle (searched, skipped or
// moved) between exec and done. The result is then loaded into the output register.
// Throughput: one item at a time; input ready only while the sequencer is idle, so
// the next transfer waits until the result is taken, longer while tready is low.
// Reset clears pointers, playing record and id counters; the entry store is not cleared.
// ----------------------------------------------------------------------------
// stream_admission_queue_unit
// Admission queue of pending streams with a playing record and id counters.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stream_admission_queue_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // action
    input  logic [saq_pkg::ACT_W-1:0]          s_axis_tuser,
    // style_tag, provider_tag, track_number, stream_number, play_now, zero pad
    input  logic [saq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // play_code, stop_request, stop_track, stop_stream, issued_id, full_error, zero pad
    output logic [saq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready
);

    saq_pkg::item_t       in_item;
    saq_pkg::seq_status_t seq_status;
    saq_pkg::result_t     seq_result;
    logic                 result_take;
    saq_pkg::mem_wr_t     mem_wr;
    saq_pkg::ptr_t        mem_rd_addr;
    saq_pkg::entry_t      mem_rd_data;
    saq_pkg::tag_pair_t   cmp_a, cmp_b;
    logic                 cmp_hit;

    logic                 out_valid_reg, out_valid_next;
    saq_pkg::result_t     out_reg;

    // Unpack input transfer
    assign in_item.action        = s_axis_tuser;
    assign in_item.style_tag     = s_axis_tdata[saq_pkg::TAG_W-1:0];
    assign in_item.provider_tag  = s_axis_tdata[32 +: saq_pkg::TAG_W];
    assign in_item.track_number  = s_axis_tdata[95:64];
    assign in_item.stream_number = s_axis_tdata[127:96];
    assign in_item.play_now      = s_axis_tdata[128];

    assign s_axis_tready = seq_status.idle;

    saq_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_item     (in_item),
        .status      (seq_status),
        .result      (seq_result),
        .result_take (result_take),
        .mem_wr      (mem_wr),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .cmp_a       (cmp_a),
        .cmp_b       (cmp_b),
        .cmp_hit     (cmp_hit)
    );

    saq_ring_mem u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    saq_match u_match (
        .a   (cmp_a),
        .b   (cmp_b),
        .hit (cmp_hit)
    );

    // Output register
    assign result_take = seq_status.done && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_take)
        begin
            out_reg <= seq_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_reg.full_error, out_reg.issued_id,
                            out_reg.stop_stream, out_reg.stop_track,
                            out_reg.stop_request, out_reg.play_code};

    // Checks
    `ASSERT_PROP(a_busy_after_accept, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input ready right after an accepted transfer")
    `ASSERT_PROP(a_load_from_done, $rose(m_axis_tvalid) |-> $past(seq_status.done), "output valid rose without a finished item")
    `ASSERT_PROP(a_single_outcome, m_axis_tvalid |-> $onehot0({out_reg.full_error, out_reg.stop_request, (out_reg.play_code != saq_pkg::PLAY_NO)}), "result mixes outcomes of different actions")

endmodule

// ===== test/stream_admission_queue_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_admission_queue_unit_tb
// Drives action transfers into the admission queue and checks every result
// transfer field by field against the typed row of the table or against an
// in-bench model of the pending ring, the playing record and the id counters.
// A short directed table runs first, then random sequences around the live ring.
// ----------------------------------------------------------------------------
module stream_admission_queue_unit_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 900;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 2 * saq_pkg::DEPTH + 8;

    typedef struct {
        saq_pkg::item_t   it;
        logic             typed;
        saq_pkg::result_t want;
    } script_row_t;

    logic                                clk;
    logic                                rst_n;
    logic [saq_pkg::ACT_W-1:0]           s_axis_tuser;
    logic [saq_pkg::IN_TDATA_W-1:0]      s_axis_tdata;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [saq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;

    // Model state: pending ring, playing record, id counters
    saq_pkg::entry_t  ring [saq_pkg::DEPTH];
    saq_pkg::ptr_t    ring_head;
    saq_pkg::ptr_t    ring_tail;
    logic             live_valid;
    saq_pkg::entry_t  live_rec;
    saq_pkg::id_t     track_ctr;
    saq_pkg::id_t     stream_ctr;

    saq_pkg::result_t awaited[$];
    script_row_t      script[$];
    saq_pkg::tag_t    style_pool [4];
    saq_pkg::tag_t    prov_pool [3];
    int               fill_left;
    int               mismatch_count;
    int               cycle_count;
    logic             calm;
    logic             hold_request;

    stream_admission_queue_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    // 100 MHz clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic saq_pkg::ptr_t next_slot(input saq_pkg::ptr_t p);
        return (int'(p) == saq_pkg::DEPTH - 1) ? saq_pkg::ptr_t'(0)
                                               : saq_pkg::ptr_t'(p + 1'b1);
    endfunction

    function automatic logic tags_hit(input saq_pkg::entry_t e, input saq_pkg::tag_t s,
                                      input saq_pkg::tag_t p);
        return (e.style_tag == s) && (e.provider_tag == p);
    endfunction

    // Step past a run of tag-matching entries starting at i
    function automatic saq_pkg::ptr_t skip_matching(input saq_pkg::ptr_t i,
                                                    input saq_pkg::tag_t s,
                                                    input saq_pkg::tag_t p);
        while (i != ring_tail && tags_hit(ring[i], s, p))
        begin
            i = next_slot(i);
        end
        return i;
    endfunction

    function automatic int occupancy();
        return (int'(ring_tail) - int'(ring_head) + saq_pkg::DEPTH) % saq_pkg::DEPTH;
    endfunction

    // Apply one accepted action to the model and return its result
    function automatic saq_pkg::result_t admit_item(input saq_pkg::item_t it);
        saq_pkg::result_t r;
        logic             live_hit;
        logic             found;
        logic             at_front;
        saq_pkg::ptr_t    idx;
        saq_pkg::ptr_t    prev;
        r = '0;
        live_hit = live_valid && live_rec.style_tag == it.style_tag
                   && live_rec.provider_tag == it.provider_tag;
        case (it.action)
            saq_pkg::ACT_PUSH:
            begin
                if (next_slot(ring_tail) == ring_head)
                begin
                    r.full_error = 1'b1;
                end
                else
                begin
                    ring[ring_tail] = '{it.style_tag, it.provider_tag, it.track_number,
                                        it.stream_number, it.play_now};
                    ring_tail = next_slot(ring_tail);
                end
            end
            saq_pkg::ACT_PLAY_CHECK:
            begin
                if (ring_head != ring_tail && ring[ring_head].track_number == it.track_number
                    && ring[ring_head].stream_number == it.stream_number)
                begin
                    live_valid = 1'b1;
                    live_rec = ring[ring_head];
                    ring_head = next_slot(ring_head);
                    r.play_code = live_rec.play_now ? saq_pkg::PLAY_YES : saq_pkg::PLAY_LATER;
                end
            end
            saq_pkg::ACT_INV_AT:
            begin
                found = live_hit;
                at_front = live_hit;
                if (live_hit)
                begin
                    r.stop_request = 1'b1;
                    r.stop_track = live_rec.track_number;
                    r.stop_stream = live_rec.stream_number;
                end
                if (ring_head != ring_tail)
                begin
                    idx = ring_head;
                    prev = idx;
                    // locate the first matching entry
                    while (!found && idx != ring_tail)
                    begin
                        found = tags_hit(ring[idx], it.style_tag, it.provider_tag);
                        if (found && idx == ring_head)
                        begin
                            at_front = 1'b1;
                        end
                        prev = idx;
                        idx = next_slot(idx);
                    end
                    if (found)
                    begin
                        idx = skip_matching(idx, it.style_tag, it.provider_tag);
                        if (at_front)
                        begin
                            ring_head = idx;
                        end
                        else
                        begin
                            // close the gap left by the run
                            while (idx != ring_tail)
                            begin
                                ring[prev] = ring[idx];
                                prev = next_slot(prev);
                                idx = next_slot(idx);
                            end
                            ring_tail = prev;
                        end
                    end
                end
            end
            saq_pkg::ACT_INV_AFTER:
            begin
                idx = ring_head;
                found = live_hit;
                while (!found && idx != ring_tail)
                begin
                    if (tags_hit(ring[idx], it.style_tag, it.provider_tag))
                    begin
                        found = 1'b1;
                    end
                    else
                    begin
                        idx = next_slot(idx);
                    end
                end
                if (found)
                begin
                    ring_tail = skip_matching(idx, it.style_tag, it.provider_tag);
                end
            end
            saq_pkg::ACT_NEW_TRACK:
            begin
                r.issued_id = track_ctr;
                track_ctr = track_ctr + 1'b1;
            end
            saq_pkg::ACT_NEW_STREAM:
            begin
                r.issued_id = stream_ctr;
                stream_ctr = stream_ctr + 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic saq_pkg::item_t mk(input logic [saq_pkg::ACT_W-1:0] a,
                                          input saq_pkg::tag_t s, input saq_pkg::tag_t p,
                                          input saq_pkg::id_t t, input saq_pkg::id_t st,
                                          input logic n);
        saq_pkg::item_t it;
        it.action = a;
        it.style_tag = s;
        it.provider_tag = p;
        it.track_number = t;
        it.stream_number = st;
        it.play_now = n;
        return it;
    endfunction

    function automatic saq_pkg::result_t mk_res(input logic [1:0] code, input logic stop,
                                                input saq_pkg::id_t st,
                                                input saq_pkg::id_t ss,
                                                input saq_pkg::id_t iss, input logic full);
        saq_pkg::result_t r;
        r.play_code = code;
        r.stop_request = stop;
        r.stop_track = st;
        r.stop_stream = ss;
        r.issued_id = iss;
        r.full_error = full;
        return r;
    endfunction

    // Random action, partly aimed at tags and ids that are live in the ring
    function automatic saq_pkg::item_t make_item();
        saq_pkg::item_t it;
        int             pick;
        int             k;
        saq_pkg::ptr_t  slot;
        logic           busy;
        busy = (ring_head != ring_tail);
        it.action = saq_pkg::ACT_PUSH;
        it.style_tag = style_pool[$urandom_range(0, 3)];
        it.provider_tag = prov_pool[$urandom_range(0, 2)];
        if ($urandom_range(0, 9) == 0)
        begin
            it.style_tag = $urandom;
            it.provider_tag = $urandom;
        end
        it.track_number = $urandom;
        it.stream_number = $urandom;
        it.play_now = 1'($urandom);
        if (fill_left > 0)
        begin
            fill_left--;
            return it;
        end
        pick = $urandom_range(0, 99);
        if (pick < 4)
        begin
            // burst of pushes that can run into the full ring
            fill_left = $urandom_range(10, 18);
        end
        else if (pick < 35)
        begin
            it.action = saq_pkg::ACT_PUSH;
        end
        else if (pick < 60)
        begin
            it.action = saq_pkg::ACT_PLAY_CHECK;
            if (busy && $urandom_range(0, 3) != 0)
            begin
                it.track_number = ring[ring_head].track_number;
                it.stream_number = ring[ring_head].stream_number;
            end
            else if (busy && ($urandom & 1))
            begin
                it.track_number = ring[ring_head].track_number;
                it.stream_number = ring[ring_head].stream_number
                                   ^ (saq_pkg::id_t'(1) << $urandom_range(0, 31));
            end
        end
        else if (pick < 85)
        begin
            it.action = (pick < 75) ? saq_pkg::ACT_INV_AT : saq_pkg::ACT_INV_AFTER;
            if (live_valid && $urandom_range(0, 3) == 0)
            begin
                it.style_tag = live_rec.style_tag;
                it.provider_tag = live_rec.provider_tag;
            end
            else if (busy && $urandom_range(0, 2) == 0)
            begin
                k = $urandom_range(0, occupancy() - 1);
                slot = saq_pkg::ptr_t'((int'(ring_head) + k) % saq_pkg::DEPTH);
                it.style_tag = ring[slot].style_tag;
                it.provider_tag = ring[slot].provider_tag;
            end
        end
        else if (pick < 91)
        begin
            it.action = saq_pkg::ACT_NEW_TRACK;
        end
        else if (pick < 97)
        begin
            it.action = saq_pkg::ACT_NEW_STREAM;
        end
        else
        begin
            it.action = ($urandom & 1) ? saq_pkg::ACT_RSVD7 : saq_pkg::ACT_RSVD6;
        end
        return it;
    endfunction

    // Compare one result transfer with the oldest expectation
    task automatic check_result(input logic [saq_pkg::OUT_TDATA_W-1:0] d);
        saq_pkg::result_t got;
        saq_pkg::result_t want;
        if (awaited.size() == 0)
        begin
            $error("result transfer with nothing awaited: %h", d);
            mismatch_count++;
            return;
        end
        want = awaited.pop_front();
        got.play_code = d[1:0];
        got.stop_request = d[2];
        got.stop_track = d[34:3];
        got.stop_stream = d[66:35];
        got.issued_id = d[98:67];
        got.full_error = d[99];
        if (got.play_code !== want.play_code)
        begin
            $error("play_code: expected %0d, got %0d", want.play_code, got.play_code);
            mismatch_count++;
        end
        if (got.stop_request !== want.stop_request)
        begin
            $error("stop_request: expected %0d, got %0d", want.stop_request, got.stop_request);
            mismatch_count++;
        end
        if (got.stop_track !== want.stop_track)
        begin
            $error("stop_track: expected %h, got %h", want.stop_track, got.stop_track);
            mismatch_count++;
        end
        if (got.stop_stream !== want.stop_stream)
        begin
            $error("stop_stream: expected %h, got %h", want.stop_stream, got.stop_stream);
            mismatch_count++;
        end
        if (got.issued_id !== want.issued_id)
        begin
            $error("issued_id: expected %h, got %h", want.issued_id, got.issued_id);
            mismatch_count++;
        end
        if (got.full_error !== want.full_error)
        begin
            $error("full_error: expected %0d, got %0d", want.full_error, got.full_error);
            mismatch_count++;
        end
    endtask

    // Offer one action and record its expectation once the transfer happens
    task automatic offer(input saq_pkg::item_t it, input logic typed,
                         input saq_pkg::result_t want);
        int               gap;
        saq_pkg::result_t predicted;
        gap = 0;
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 37)
            begin
                gap++;
            end
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tuser <= it.action;
        s_axis_tdata <= saq_pkg::IN_TDATA_W'({it.play_now, it.stream_number,
                                              it.track_number, it.provider_tag,
                                              it.style_tag});
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!(s_axis_tready && rst_n));
        predicted = admit_item(it);
        awaited.push_back(typed ? want : predicted);
    endtask

    // Stop offering until every awaited result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (awaited.size() != 0);
    endtask

    task automatic add_row(input saq_pkg::item_t it, input logic typed,
                           input saq_pkg::result_t want);
        script.push_back('{it, typed, want});
    endtask

    // Receiver: checks transfers, random back-pressure and one long hold-off
    initial
    begin
        int  hold_left;
        logic hold_started;
        hold_left = 0;
        hold_started = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                check_result(m_axis_tdata);
            end
            if (hold_request && !hold_started)
            begin
                hold_started = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (calm)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= 37);
            end
        end
    end

    // Sender: directed table, then random sequences
    initial
    begin
        saq_pkg::item_t   it;
        saq_pkg::result_t nil;
        saq_pkg::id_t     ones;
        nil = '0;
        ones = '1;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = '0;
        s_axis_tdata = '0;
        calm = 1'b0;
        hold_request = 1'b0;
        fill_left = 0;
        mismatch_count = 0;
        ring_head = '0;
        ring_tail = '0;
        live_valid = 1'b0;
        live_rec = '0;
        track_ctr = '0;
        stream_ctr = '0;
        style_pool = '{32'h0, 32'hFFFF_FFFF, $urandom, $urandom};
        prov_pool = '{32'h0, 32'hFFFF_FFFF, $urandom};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Counters from reset, empty ring, reserved codes
        add_row(mk(saq_pkg::ACT_NEW_TRACK, 0, 0, 0, 0, 0), 1,
                mk_res(saq_pkg::PLAY_NO, 0, 0, 0, 0, 0));
        add_row(mk(saq_pkg::ACT_NEW_TRACK, 0, 0, 0, 0, 0), 1,
                mk_res(saq_pkg::PLAY_NO, 0, 0, 0, 1, 0));
        add_row(mk(saq_pkg::ACT_NEW_STREAM, 0, 0, 0, 0, 0), 1,
                mk_res(saq_pkg::PLAY_NO, 0, 0, 0, 0, 0));
        add_row(mk(saq_pkg::ACT_PLAY_CHECK, 0, 0, 0, 0, 0), 1, nil);
        add_row(mk(saq_pkg::ACT_INV_AT, 0, 0, 0, 0, 0), 1, nil);
        add_row(mk(saq_pkg::ACT_INV_AFTER, 0, 0, 0, 0, 0), 1, nil);
        add_row(mk(saq_pkg::ACT_RSVD6, ones, ones, ones, ones, 1), 1, nil);
        add_row(mk(saq_pkg::ACT_RSVD7, ones, ones, ones, ones, 1), 1, nil);
        // Play check: id mismatch, play now, play later
        add_row(mk(saq_pkg::ACT_PUSH, 1, 2, 10, 20, 1), 1, nil);
        add_row(mk(saq_pkg::ACT_PLAY_CHECK, 0, 0, 11, 20, 0), 1, nil);
        add_row(mk(saq_pkg::ACT_PLAY_CHECK, 0, 0, 10, 20, 0), 1,
                mk_res(saq_pkg::PLAY_YES, 0, 0, 0, 0, 0));
        add_row(mk(saq_pkg::ACT_PUSH, ones, ones, ones, ones, 0), 1, nil);
        add_row(mk(saq_pkg::ACT_PLAY_CHECK, 0, 0, ones, ones, 0), 1,
                mk_res(saq_pkg::PLAY_LATER, 0, 0, 0, 0, 0));
        // Playing record hit with an empty ring
        add_row(mk(saq_pkg::ACT_INV_AT, ones, ones, 0, 0, 0), 1,
                mk_res(saq_pkg::PLAY_NO, 1, ones, ones, 0, 0));
        // Mid-ring run removal with compaction, then truncation
        add_row(mk(saq_pkg::ACT_PUSH, 1, 2, 30, 31, 1), 0, nil);
        add_row(mk(saq_pkg::ACT_PUSH, 3, 4, 32, 33, 0), 0, nil);
        add_row(mk(saq_pkg::ACT_PUSH, 3, 4, 34, 35, 1), 0, nil);
        add_row(mk(saq_pkg::ACT_PUSH, 1, 2, 36, 37, 0), 0, nil);
        add_row(mk(saq_pkg::ACT_INV_AT, 3, 4, 0, 0, 0), 0, nil);
        add_row(mk(saq_pkg::ACT_PUSH, 5, 6, 38, 39, 1), 0, nil);
        add_row(mk(saq_pkg::ACT_INV_AFTER, 1, 2, 0, 0, 0), 0, nil);
        // Playing record hit with unmatched entries in the ring
        add_row(mk(saq_pkg::ACT_INV_AT, ones, ones, 0, 0, 0), 0, nil);
        add_row(mk(saq_pkg::ACT_INV_AFTER, ones, ones, 0, 0, 0), 0, nil);
        add_row(mk(saq_pkg::ACT_PLAY_CHECK, 0, 0, 30, 31, 0), 0, nil);

        foreach (script[i])
        begin
            offer(script[i].it, script[i].typed, script[i].want);
        end
        drain();

        // Random sequences
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 300)
            begin
                hold_request = 1'b1;
            end
            if (n == 600)
            begin
                drain();
            end
            calm = (n >= 450 && n < 550);
            it = make_item();
            offer(it, 1'b0, nil);
        end
        calm = 1'b0;
        drain();
        repeat (SETTLE) @(posedge clk);

        if (mismatch_count == 0 && awaited.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
